// ----- hdl/dob_pkg.sv -----
package dob_pkg;

  // Sequencer states of the observer step.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OBS,
    ST_OBS_WAIT,
    ST_INT,
    ST_INT_WAIT,
    ST_STEP,
    ST_STEP_WAIT,
    ST_SUM,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DONE
  } dob_state_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_AUX  = 2'd2;

  // Reset value of the integration step register.
  localparam int TS_RESET = 66;

endpackage

// ----- hdl/disturbance_observer_compensator.sv -----
// Each accepted input word runs through three passes of the bit-serial multipliers
// and, unless the input gain is zero, one pass of the divider before the result word
// is loaded. A new input word is taken only after the previous one has been loaded.
// Reset (synchronous, active high) loads the gain with 1.0, the step with 66 and
// the observer variable with zero, and empties the output register.
module disturbance_observer_compensator
  import dob_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  localparam int APB_W  = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = (DATA_WIDTH > 32) ? 5 : 4
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [APB_W-1:0]             pwdata,
  output logic [APB_W-1:0]             prdata,
  output logic                         pready,
  // Input words.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] state_meas,
  input  logic signed [DATA_WIDTH-1:0] drift_term,
  input  logic signed [DATA_WIDTH-1:0] input_gain,
  input  logic signed [DATA_WIDTH-1:0] applied_control,
  input  logic signed [DATA_WIDTH-1:0] nominal_command,
  // Result words.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] disturbance_est,
  output logic signed [DATA_WIDTH-1:0] compensated_command,
  output logic                         divide_fault
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam logic [FB:0] TS_ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [DW+1:0] SUM_MAX = {3'b000, {(DW - 1){1'b1}}};
  localparam logic signed [DW+1:0] SUM_MIN = {3'b111, {(DW - 1){1'b0}}};

  // Sign-extend a data word by two bits so that any sum or difference of two
  // words fits before it is clamped.
  function automatic logic signed [DW+1:0] widen(input logic signed [DW-1:0] a);
    widen = $signed({{2{a[DW-1]}}, a});
  endfunction

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW+1:0] v);
    logic signed [DW-1:0] r;
    if (v > SUM_MAX) begin
      r = SUM_MAX[DW-1:0];
    end else if (v < SUM_MIN) begin
      r = SUM_MIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    clamp = r;
  endfunction

  // Configuration registers.
  logic [DW-2:0]        gain;
  logic [FB:0]          tstep;
  logic signed [DW-1:0] aux_init;
  logic [1:0]           reg_idx;
  logic                 cfg_wr;

  // Observer state: the auxiliary variable z.
  logic signed [DW-1:0] aux_var;

  // Captured input word and intermediate results of one step.
  logic signed [DW-1:0] x_r;
  logic signed [DW-1:0] f_r;
  logic signed [DW-1:0] g_r;
  logic signed [DW-1:0] u_r;
  logic signed [DW-1:0] usmc_r;
  logic signed [DW-1:0] p_r;
  logic signed [DW-1:0] s_r;
  logic signed [DW-1:0] lz_r;
  logic signed [DW-1:0] zdot_r;
  logic signed [DW-1:0] dhat_r;

  dob_state_t state;
  dob_state_t state_next;

  logic                 mul_start;
  logic                 side_start;
  logic                 div_start;
  logic                 out_load;
  logic                 in_take;
  logic                 g_zero;
  logic signed [DW-1:0] gain_s;
  logic [FB:0]          dt;
  logic signed [DW-1:0] dt_s;
  logic signed [DW-1:0] mul0_a;
  logic signed [DW-1:0] mul0_b;
  logic signed [DW-1:0] mul0_res;
  logic signed [DW-1:0] mul1_res;
  logic signed [DW-1:0] mul2_res;
  logic signed [DW-1:0] div_res;
  logic                 mul0_done;
  logic                 mul1_done;
  logic                 mul2_done;
  logic                 div_done;

  // ------------------------------------------------------------------
  // Configuration port. Accesses complete at once, so pready is tied high.
  // The register index is the word address; writing aux_init also
  // preloads the observer variable straight away.
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1 -: 2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= (DW - 1)'(1) << FB;
      tstep    <= (FB + 1)'(TS_RESET);
      aux_init <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN: gain     <= pwdata[DW-2:0];
        REG_STEP: tstep    <= pwdata[FB:0];
        REG_AUX:  aux_init <= $signed(pwdata[DW-1:0]);
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN: prdata = APB_W'(gain);
      REG_STEP: prdata = APB_W'(tstep);
      REG_AUX:  prdata = APB_W'(aux_init);
      default:  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Arithmetic units. Unit 0 is shared across the three multiply passes:
  // first L*x (alongside g*u on unit 1 and L*z on unit 2), then L*s, then
  // zdot*dt. A step above 1.0 is clamped to exactly 1.0.
  // ------------------------------------------------------------------
  assign gain_s = $signed({1'b0, gain});
  assign dt     = (tstep > TS_ONE) ? TS_ONE : tstep;
  assign dt_s   = $signed(DW'(dt));
  assign g_zero = (g_r == '0);

  always_comb begin
    unique case (state)
      ST_INT: begin
        mul0_a = gain_s;
        mul0_b = s_r;
      end
      ST_STEP: begin
        mul0_a = zdot_r;
        mul0_b = dt_s;
      end
      default: begin
        mul0_a = gain_s;
        mul0_b = x_r;
      end
    endcase
  end

  dob_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_mul0 (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .op_a   (mul0_a),
    .op_b   (mul0_b),
    .result (mul0_res),
    .done   (mul0_done)
  );

  dob_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_mul1 (
    .clk    (clk),
    .rst    (rst),
    .start  (side_start),
    .op_a   (g_r),
    .op_b   (u_r),
    .result (mul1_res),
    .done   (mul1_done)
  );

  dob_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_mul2 (
    .clk    (clk),
    .rst    (rst),
    .start  (side_start),
    .op_a   (gain_s),
    .op_b   (aux_var),
    .result (mul2_res),
    .done   (mul2_done)
  );

  // The compensation quotient d_hat/g; only run when g is non-zero.
  dob_div #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .numer  (dhat_r),
    .denom  (g_r),
    .result (div_res),
    .done   (div_done)
  );

  // ------------------------------------------------------------------
  // Step sequencer.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    side_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_OBS;
        end
      end
      ST_OBS: begin
        mul_start  = 1'b1;
        side_start = 1'b1;
        state_next = ST_OBS_WAIT;
      end
      ST_OBS_WAIT: begin
        if (mul0_done && mul1_done && mul2_done) begin
          state_next = ST_INT;
        end
      end
      ST_INT: begin
        mul_start  = 1'b1;
        state_next = ST_INT_WAIT;
      end
      ST_INT_WAIT: begin
        if (mul0_done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        mul_start  = 1'b1;
        state_next = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: begin
        if (mul0_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = g_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait here only while the previous result word is still unread.
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_take = in_valid & in_ready;

  // ------------------------------------------------------------------
  // Datapath registers. Every sum is clamped to the word range before it
  // is used again.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r    <= state_meas;
      f_r    <= drift_term;
      g_r    <= input_gain;
      u_r    <= applied_control;
      usmc_r <= nominal_command;
    end
    if (state == ST_OBS_WAIT && mul0_done) begin
      p_r  <= mul0_res;
      s_r  <= clamp(widen(f_r) + widen(mul1_res));
      lz_r <= mul2_res;
    end
    if (state == ST_INT_WAIT && mul0_done) begin
      zdot_r <= clamp(-widen(lz_r) - widen(mul0_res));
    end
    if (state == ST_SUM) begin
      dhat_r <= clamp(widen(aux_var) + widen(p_r));
    end
  end

  // The observer variable: preloaded by a configuration write, advanced by
  // one Euler step per input word.
  always_ff @(posedge clk) begin
    if (rst) begin
      aux_var <= '0;
    end else if (cfg_wr && reg_idx == REG_AUX) begin
      aux_var <= $signed(pwdata[DW-1:0]);
    end else if (state == ST_STEP_WAIT && mul0_done) begin
      aux_var <= clamp(widen(aux_var) + widen(mul0_res));
    end
  end

  // ------------------------------------------------------------------
  // Output register. It holds one finished word; the block goes back to
  // idle as soon as the word is loaded, so a new input word can be taken
  // while this one waits to be read.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      disturbance_est <= dhat_r;
      divide_fault    <= g_zero;
      // With a zero input gain the nominal command passes unchanged.
      compensated_command <= g_zero ? usmc_r : clamp(widen(usmc_r) - widen(div_res));
    end
  end

endmodule

// ----- hdl/dob_mul.sv -----
module dob_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic signed [DATA_WIDTH-1:0] op_b,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         done
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int PW = 2 * DW;
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW - 1){1'b0}}};

  logic [DW-1:0] a_mag;
  logic [DW-1:0] b_mag;
  logic [DW-1:0] ma;
  logic [DW-1:0] hi;
  logic [DW-1:0] lo;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [DW:0]   sum;
  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;
  logic          ovf_pos;
  logic          ovf_neg;

  assign a_mag = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
  assign b_mag = op_b[DW-1] ? (~op_b + 1'b1) : op_b;

  // One multiplier bit per cycle: add the multiplicand when the bit is set,
  // then shift the partial product and the multiplier right together.
  assign sum = {1'b0, hi} + {1'b0, (lo[0] ? ma : {DW{1'b0}})};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a_mag;
      lo  <= b_mag;
      hi  <= '0;
      neg <= op_a[DW-1] ^ op_b[DW-1];
    end else if (cnt != '0) begin
      hi <= sum[DW:1];
      lo <= {sum[0], lo[DW-1:1]};
    end
  end

  // Drop the fraction bits, truncating the magnitude, then saturate.
  assign prod    = {hi, lo};
  assign shifted = prod >> FB;
  assign ovf_pos = |shifted[PW-1:DW-1];
  assign ovf_neg = (|shifted[PW-1:DW]) | (shifted[DW-1] & (|shifted[DW-2:0]));

  always_comb begin
    if (neg) begin
      result = ovf_neg ? $signed(NEG_MIN) : $signed(~shifted[DW-1:0] + 1'b1);
    end else begin
      result = ovf_pos ? $signed(POS_MAX) : $signed(shifted[DW-1:0]);
    end
  end

endmodule

// ----- hdl/dob_div.sv -----
module dob_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] numer,
  input  logic signed [DATA_WIDTH-1:0] denom,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         done
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int QW = DW + FB;
  localparam int CW = $clog2(QW + 1);
  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW - 1){1'b0}}};

  logic [DW-1:0] n_mag;
  logic [DW-1:0] d_mag;
  logic [DW-1:0] md;
  logic [QW-1:0] dv;
  logic [DW-1:0] rem;
  logic [QW-1:0] quot;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic          ovf_pos;
  logic          ovf_neg;

  assign n_mag = numer[DW-1] ? (~numer + 1'b1) : numer;
  assign d_mag = denom[DW-1] ? (~denom + 1'b1) : denom;

  // Restoring division, one quotient bit per cycle. The remainder stays
  // below the divisor, so it never needs more than DW bits.
  assign trial = {rem, dv[QW-1]};
  assign diff  = trial - {1'b0, md};
  assign fits  = trial >= {1'b0, md};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(QW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv   <= {n_mag, {FB{1'b0}}};
      md   <= d_mag;
      rem  <= '0;
      quot <= '0;
      neg  <= numer[DW-1] ^ denom[DW-1];
    end else if (cnt != '0) begin
      dv   <= {dv[QW-2:0], 1'b0};
      rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quot <= {quot[QW-2:0], fits};
    end
  end

  assign ovf_pos = |quot[QW-1:DW-1];
  assign ovf_neg = (|quot[QW-1:DW]) | (quot[DW-1] & (|quot[DW-2:0]));

  always_comb begin
    if (neg) begin
      result = ovf_neg ? $signed(NEG_MIN) : $signed(~quot[DW-1:0] + 1'b1);
    end else begin
      result = ovf_pos ? $signed(POS_MAX) : $signed(quot[DW-1:0]);
    end
  end

endmodule

// ----- hdl/dob_checker.sv -----
module dob_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         pready,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] disturbance_est,
  input logic signed [DATA_WIDTH-1:0] compensated_command,
  input logic                         divide_fault
);

  // One word is worked on at a time: taking a word closes the input.
  ap_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while a word is in progress");

  // A new result appears only as the block returns to idle.
  ap_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result word raised while the block is still busy");

  // A waiting result word holds until it is read.
  ap_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(disturbance_est)
      && $stable(compensated_command) && $stable(divide_fault)))
    else $error("result word changed or dropped before it was read");

  // The configuration port never inserts wait states.
  ap_no_wait: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("configuration port stalled");

endmodule

bind disturbance_observer_compensator dob_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dob_checker (
  .clk                 (clk),
  .rst                 (rst),
  .pready              (pready),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .disturbance_est     (disturbance_est),
  .compensated_command (compensated_command),
  .divide_fault        (divide_fault)
);
